### rtl/core/fdp_pkg.sv
// Package for the frame delta pacer: widths, reset values, request and
// register codes, and the configuration and stage link types.
// No dependencies; every other file imports it.
package fdp_pkg;

	localparam int CNT_W      = 48;
	localparam int HIST_LOG2  = 2;
	localparam int HIST_DEPTH = 1 << HIST_LOG2;
	localparam int REG_W      = 26;
	localparam int DELTA_W    = REG_W + 3;
	localparam int SUM_W      = DELTA_W + HIST_LOG2;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [REG_W-1:0] RST_FRAME_PERIOD = REG_W'(16666666);
	localparam logic [REG_W-1:0] RST_SNAP_TOL     = REG_W'(200000);
	localparam logic [REG_W-1:0] RST_SNAP_BASE    = REG_W'(16666666);

	localparam logic [1:0] REQ_SAMPLE   = 2'd0;
	localparam logic [1:0] REQ_CONS_ACC = 2'd1;
	localparam logic [1:0] REQ_CONS_DLT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAP_TOL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAP_BASE    = 2'd2;

	typedef struct packed {
		logic [REG_W-1:0] frame_period;
		logic [REG_W-1:0] snap_tol;
		logic [REG_W-1:0] snap_base;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         req;
		logic [DELTA_W-1:0] delta;
	} link_t;

endpackage

### rtl/core/fdp_if.sv
// Valid/ready channel interfaces for request input and result output.
// Depends on fdp_pkg for field widths.
interface fdp_req_if import fdp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [CNT_W-1:0] timestamp;

	modport source (output valid, output req_type, output timestamp, input ready);
	modport sink (input valid, input req_type, input timestamp, output ready);
endinterface

interface fdp_res_if import fdp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [DELTA_W-1:0]       smoothed_delta;
	logic signed [TIME_W-1:0] accumulated_time;
	logic signed [TIME_W-1:0] consumed_time;
	logic                     resync_done;

	modport source (output valid, output smoothed_delta, output accumulated_time,
		output consumed_time, output resync_done, input ready);
	modport sink (input valid, input smoothed_delta, input accumulated_time,
		input consumed_time, input resync_done, output ready);
endinterface

### rtl/core/fdp_front.sv
// Front stage: timestamp difference, clamp and snap to display periods,
// registered into stage one. Depends on fdp_pkg and fdp_req_if.
module fdp_front import fdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	fdp_req_if.sink     sample,
	input  logic        next_ready,
	output link_t       link
);

	logic               valid_s1;
	logic [1:0]         req_s1;
	logic [DELTA_W-1:0] delta_s1;
	logic [CNT_W-1:0]   last_ts_q;

	logic [CNT_W-1:0]   diff;
	logic [DELTA_W-1:0] limit;
	logic [DELTA_W-1:0] clamped;
	logic [DELTA_W-1:0] snapped;
	logic [DELTA_W-1:0] base_ext;
	logic [DELTA_W-1:0] tol_ext;
	logic [DELTA_W-1:0] cand [5];
	logic [DELTA_W-1:0] gap [5];
	logic [4:0]         hit;

	assign sample.ready = !valid_s1 || next_ready;

	always_comb begin
		diff = (sample.timestamp < last_ts_q) ? '0 : sample.timestamp - last_ts_q;
		limit = {cfg.frame_period, 3'b000};
		if (diff > {{(CNT_W-DELTA_W){1'b0}}, limit}) begin
			clamped = {3'b000, cfg.frame_period};
		end else begin
			clamped = diff[DELTA_W-1:0];
		end
		base_ext = {3'b000, cfg.snap_base};
		tol_ext = {3'b000, cfg.snap_tol};
		cand[0] = base_ext;
		cand[1] = base_ext << 1;
		cand[2] = (base_ext << 1) + base_ext;
		cand[3] = base_ext << 2;
		cand[4] = (base_ext + DELTA_W'(1)) >> 1;
		for (int i = 0; i < 5; i++) begin
			gap[i] = (clamped > cand[i]) ? clamped - cand[i] : cand[i] - clamped;
			hit[i] = gap[i] < tol_ext;
		end
		if (hit[0]) begin
			snapped = cand[0];
		end else if (hit[1]) begin
			snapped = cand[1];
		end else if (hit[2]) begin
			snapped = cand[2];
		end else if (hit[3]) begin
			snapped = cand[3];
		end else if (hit[4]) begin
			snapped = cand[4];
		end else begin
			snapped = clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_ts_q <= '0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
			if (sample.valid && sample.req_type == REQ_SAMPLE) begin
				last_ts_q <= sample.timestamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			req_s1 <= sample.req_type;
			delta_s1 <= snapped;
		end
	end

	assign link = '{valid: valid_s1, req: req_s1, delta: delta_s1};

endmodule

### rtl/core/fdp_back.sv
// Back stage: delta history and average, frame accumulator with resync,
// consumed delta, and the result register. Depends on fdp_pkg and fdp_res_if.
module fdp_back import fdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  link_t       link,
	output logic        take_ready,
	fdp_res_if.source   result
);

	logic [DELTA_W-1:0]       hist_q [HIST_DEPTH];
	logic signed [TIME_W-1:0] acc_q;
	logic signed [TIME_W-1:0] cons_q;
	logic [DELTA_W-1:0]       cur_delta_q;

	logic                     valid_s2;
	logic [DELTA_W-1:0]       delta_s2;
	logic signed [TIME_W-1:0] acc_s2;
	logic signed [TIME_W-1:0] cons_s2;
	logic                     resync_s2;

	logic [SUM_W-1:0]         sum;
	logic [DELTA_W-1:0]       avg;
	logic [DELTA_W-1:0]       limit;
	logic signed [TIME_W-1:0] acc_add;
	logic signed [TIME_W-1:0] acc_sub;
	logic signed [TIME_W-1:0] cons_sub;
	logic                     resync;
	logic [DELTA_W-1:0]       new_delta;
	logic signed [TIME_W-1:0] acc_nx;
	logic signed [TIME_W-1:0] cons_nx;
	logic [DELTA_W-1:0]       delta_nx;
	logic                     resync_nx;
	logic                     take;

	function automatic logic signed [TIME_W-1:0] sat(input logic signed [TIME_W:0] v);
		logic signed [TIME_W-1:0] r;
		if (v[TIME_W] != v[TIME_W-1]) begin
			r = v[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
		end else begin
			r = v[TIME_W-1:0];
		end
		return r;
	endfunction

	assign take_ready = !valid_s2 || result.ready;
	assign take = link.valid && take_ready;

	always_comb begin
		sum = {{HIST_LOG2{1'b0}}, link.delta};
		for (int i = 1; i < HIST_DEPTH; i++) begin
			sum = sum + {{HIST_LOG2{1'b0}}, hist_q[i]};
		end
		avg = sum[SUM_W-1:HIST_LOG2];
		limit = {cfg.frame_period, 3'b000};
		acc_add = sat({acc_q[TIME_W-1], acc_q} + {{(TIME_W+1-DELTA_W){1'b0}}, avg});
		acc_sub = sat({acc_q[TIME_W-1], acc_q}
			- {{(TIME_W+1-REG_W){1'b0}}, cfg.frame_period});
		cons_sub = sat({cons_q[TIME_W-1], cons_q}
			- {{(TIME_W+1-REG_W){1'b0}}, cfg.frame_period});
		resync = acc_add > $signed({{(TIME_W-DELTA_W){1'b0}}, limit});
		new_delta = resync ? {3'b000, cfg.frame_period} : avg;

		acc_nx = acc_q;
		cons_nx = cons_q;
		delta_nx = cur_delta_q;
		resync_nx = 1'b0;
		case (link.req)
			REQ_SAMPLE: begin
				acc_nx = resync ? '0 : acc_add;
				delta_nx = new_delta;
				cons_nx = $signed({{(TIME_W-DELTA_W){1'b0}}, new_delta});
				resync_nx = resync;
			end
			REQ_CONS_ACC: begin
				acc_nx = acc_sub;
			end
			REQ_CONS_DLT: begin
				cons_nx = cons_sub;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= {3'b000, RST_FRAME_PERIOD};
			end
			acc_q <= '0;
			cons_q <= '0;
			cur_delta_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_ready) begin
				valid_s2 <= link.valid;
			end
			if (take) begin
				acc_q <= acc_nx;
				cons_q <= cons_nx;
				cur_delta_q <= delta_nx;
				if (link.req == REQ_SAMPLE) begin
					for (int i = 0; i < HIST_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HIST_DEPTH-1] <= link.delta;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			delta_s2 <= delta_nx;
			acc_s2 <= acc_nx;
			cons_s2 <= cons_nx;
			resync_s2 <= resync_nx;
		end
	end

	assign result.valid = valid_s2;
	assign result.smoothed_delta = delta_s2;
	assign result.accumulated_time = acc_s2;
	assign result.consumed_time = cons_s2;
	assign result.resync_done = resync_s2;

endmodule

### rtl/core/frame_delta_pacer.sv
// Top level of the frame delta pacer: configuration registers, front and
// back stages. Depends on fdp_pkg, fdp_if, fdp_front and fdp_back.
//
// Channel   Direction  Handshake     Payload
// sample    in         valid/ready   req_type, timestamp
// result    out        valid/ready   smoothed_delta, accumulated_time,
//                                    consumed_time, resync_done
// cfg       in         cfg_we        cfg_idx, cfg_wdata
//
// Every request passes two register stages, the front and the back stage,
// before its result is valid; a stalled result can hold it in either stage.
// A new request is taken in every cycle while the result side keeps up.
// Reset clears the timestamp, the accumulators and the current delta and
// fills the history with the reset frame period.
// A stalled result holds both stages; while the result waits, at most one more
// request is taken, and only into an empty front stage.
module frame_delta_pacer import fdp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [REG_W-1:0]     cfg_wdata,
	fdp_req_if.sink              sample,
	fdp_res_if.source            result
);

	cfg_t  cfg_q;
	link_t link;
	logic  back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_period <= RST_FRAME_PERIOD;
			cfg_q.snap_tol <= RST_SNAP_TOL;
			cfg_q.snap_base <= RST_SNAP_BASE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FRAME_PERIOD: cfg_q.frame_period <= cfg_wdata;
				CFG_SNAP_TOL:     cfg_q.snap_tol <= cfg_wdata;
				CFG_SNAP_BASE:    cfg_q.snap_base <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	fdp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (sample),
		.next_ready (back_ready),
		.link       (link)
	);

	fdp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.link       (link),
		.take_ready (back_ready),
		.result     (result)
	);

	// A resync always leaves an empty accumulator.
	a_resync_acc: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.resync_done |-> result.accumulated_time == 0)
		else $error("resync result with nonzero accumulator");

	// After a resync the consumed delta equals the reported delta.
	a_resync_cons: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.resync_done |->
		result.consumed_time == $signed({{(TIME_W-DELTA_W){1'b0}}, result.smoothed_delta}))
		else $error("resync result with mismatched consumed delta");

	// A request taken by the back stage shows up as a result in the next cycle.
	a_back_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		link.valid && back_ready |=> result.valid)
		else $error("back stage request lost");

endmodule
